// ----- sv/gbn_pkg.sv -----
`default_nettype none
package gbn_pkg;

	localparam int MAX_KEPT   = 64;
	localparam int COORD_BITS = 12;

	localparam int CNT_W  = $clog2(MAX_KEPT + 1);
	localparam int IDX_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int SLOT_W = 6;
	localparam int THR_W  = 9;
	localparam logic [THR_W-1:0] THR_RESET = 9'd115;

	localparam int AREA_W = 2 * COORD_BITS;
	localparam int SUM_W  = AREA_W + 1;
	localparam int PROD_W = SUM_W + THR_W;
	localparam int EDGE_W = COORD_BITS + 2;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0]        w;
		logic [COORD_BITS-1:0]        h;
		logic [AREA_W-1:0]            area;
	} box_t;

	typedef struct packed {
		box_t box;
		logic first;
	} qent_t;

	// low edge sign-extended, high edge = low + size, both exact
	function automatic logic signed [EDGE_W-1:0] lo_edge(logic signed [COORD_BITS-1:0] p);
		lo_edge = {{2{p[COORD_BITS-1]}}, p};
	endfunction

	function automatic logic signed [EDGE_W-1:0] hi_edge(logic signed [COORD_BITS-1:0] p,
		logic [COORD_BITS-1:0] s);
		hi_edge = lo_edge(p) + $signed({2'b00, s});
	endfunction

endpackage
`default_nettype wire

// ----- sv/gbn_if.sv -----
`default_nettype none
interface gbn_box_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [gbn_pkg::COORD_BITS-1:0] box_x;
	logic signed [gbn_pkg::COORD_BITS-1:0] box_y;
	logic [gbn_pkg::COORD_BITS-1:0]        box_w;
	logic [gbn_pkg::COORD_BITS-1:0]        box_h;
	logic                                 first_of_set;

	modport source (output valid, box_x, box_y, box_w, box_h, first_of_set, input ready);
	modport sink   (input valid, box_x, box_y, box_w, box_h, first_of_set, output ready);
endinterface

interface gbn_res_if;
	logic                            valid;
	logic                            ready;
	logic                            keep;
	logic [gbn_pkg::SLOT_W-1:0]      kept_slot;
	logic                            list_full;

	modport source (output valid, keep, kept_slot, list_full, input ready);
	modport sink   (input valid, keep, kept_slot, list_full, output ready);
endinterface
`default_nettype wire

// ----- sv/gbn_front.sv -----
`default_nettype none
module gbn_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	gbn_box_if.sink            box,
	input  wire logic          pop,
	output gbn_pkg::qent_t     head,
	output logic               head_vld
);

	gbn_pkg::qent_t                q_q [gbn_pkg::QDEPTH];
	logic [gbn_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [gbn_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [gbn_pkg::QCNT_W-1:0]    fill_q;
	logic                          push;
	logic                          do_pop;
	gbn_pkg::qent_t                ent;

	assign box.ready = (fill_q != gbn_pkg::QCNT_W'(gbn_pkg::QDEPTH));
	assign push      = box.valid && box.ready;
	assign do_pop    = pop && head_vld;
	assign head_vld  = (fill_q != '0);
	assign head      = q_q[rd_ptr_q];

	// area is formed once here so the scan only adds it
	always_comb begin
		ent.box.x    = box.box_x;
		ent.box.y    = box.box_y;
		ent.box.w    = box.box_w;
		ent.box.h    = box.box_h;
		ent.box.area = gbn_pkg::AREA_W'(box.box_w * box.box_h);
		ent.first    = box.first_of_set;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && do_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/gbn_back.sv -----
`default_nettype none
module gbn_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire gbn_pkg::qent_t              head,
	input  wire logic                        head_vld,
	output logic                             pop,
	input  wire logic [gbn_pkg::THR_W-1:0]   thr,
	gbn_res_if.source                        res
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	localparam int CW = gbn_pkg::COORD_BITS;

	state_t                       state_q;
	logic [gbn_pkg::CNT_W-1:0]    count_q;
	logic [gbn_pkg::CNT_W-1:0]    rd_addr_q;
	logic                         supp_q;
	logic                         issue;
	logic                         out_free;
	logic                         finish;
	logic                         room;
	logic                         hit;

	gbn_pkg::box_t                mem [gbn_pkg::MAX_KEPT];

	logic                         vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	gbn_pkg::box_t                b_s1;
	logic [CW-1:0]                dw_s2, dh_s2;
	logic [gbn_pkg::SUM_W-1:0]    asum_s2, asum_s3;
	logic [gbn_pkg::AREA_W-1:0]   inter_s3, inter_s4, inter_s5;
	logic [gbn_pkg::SUM_W-1:0]    uni_s4;
	logic [gbn_pkg::PROD_W-1:0]   prod_s5;
	logic                         uni_nz_s5;

	logic signed [gbn_pkg::EDGE_W-1:0] l_x, r_x, t_y, d_y;
	logic signed [gbn_pkg::EDGE_W:0]   dx, dy;
	logic [gbn_pkg::PROD_W-1:0]        inter_sh;
	logic [gbn_pkg::CNT_W+gbn_pkg::SLOT_W-1:0] slot_ext;

	assign issue    = (state_q == ST_SCAN) && (rd_addr_q != count_q);
	assign out_free = !res.valid || res.ready;
	assign finish   = (state_q == ST_DONE) && out_free;
	assign room     = (count_q < gbn_pkg::CNT_W'(gbn_pkg::MAX_KEPT));
	assign pop      = finish;
	assign slot_ext = {{gbn_pkg::SLOT_W{1'b0}}, count_q};

	// overlap extents against the box under test
	always_comb begin
		l_x = (gbn_pkg::lo_edge(head.box.x) > gbn_pkg::lo_edge(b_s1.x)) ?
			gbn_pkg::lo_edge(head.box.x) : gbn_pkg::lo_edge(b_s1.x);
		r_x = (gbn_pkg::hi_edge(head.box.x, head.box.w) < gbn_pkg::hi_edge(b_s1.x, b_s1.w)) ?
			gbn_pkg::hi_edge(head.box.x, head.box.w) : gbn_pkg::hi_edge(b_s1.x, b_s1.w);
		t_y = (gbn_pkg::lo_edge(head.box.y) > gbn_pkg::lo_edge(b_s1.y)) ?
			gbn_pkg::lo_edge(head.box.y) : gbn_pkg::lo_edge(b_s1.y);
		d_y = (gbn_pkg::hi_edge(head.box.y, head.box.h) < gbn_pkg::hi_edge(b_s1.y, b_s1.h)) ?
			gbn_pkg::hi_edge(head.box.y, head.box.h) : gbn_pkg::hi_edge(b_s1.y, b_s1.h);
		dx  = {r_x[gbn_pkg::EDGE_W-1], r_x} - {l_x[gbn_pkg::EDGE_W-1], l_x};
		dy  = {d_y[gbn_pkg::EDGE_W-1], d_y} - {t_y[gbn_pkg::EDGE_W-1], t_y};
	end

	assign inter_sh = {{(gbn_pkg::PROD_W - gbn_pkg::AREA_W - 8){1'b0}}, inter_s5, 8'h00};
	assign hit      = vld_s5 && uni_nz_s5 && (inter_sh > prod_s5);

	// kept list
	always_ff @(posedge clk) begin
		if (finish && !supp_q && room) begin
			mem[count_q[gbn_pkg::IDX_W-1:0]] <= head.box;
		end
		if (issue) begin
			b_s1 <= mem[rd_addr_q[gbn_pkg::IDX_W-1:0]];
		end
	end

	// compare pipeline payload
	always_ff @(posedge clk) begin
		dw_s2     <= (dx > 0) ? dx[CW-1:0] : '0;
		dh_s2     <= (dy > 0) ? dy[CW-1:0] : '0;
		asum_s2   <= gbn_pkg::SUM_W'(head.box.area) + gbn_pkg::SUM_W'(b_s1.area);
		inter_s3  <= gbn_pkg::AREA_W'(dw_s2 * dh_s2);
		asum_s3   <= asum_s2;
		uni_s4    <= asum_s3 - gbn_pkg::SUM_W'(inter_s3);
		inter_s4  <= inter_s3;
		prod_s5   <= gbn_pkg::PROD_W'(thr * uni_s4);
		inter_s5  <= inter_s4;
		uni_nz_s5 <= (uni_s4 != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			rd_addr_q     <= '0;
			supp_q        <= 1'b0;
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			vld_s3        <= 1'b0;
			vld_s4        <= 1'b0;
			vld_s5        <= 1'b0;
			res.valid     <= 1'b0;
			res.keep      <= 1'b0;
			res.kept_slot <= '0;
			res.list_full <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			if (hit) begin
				supp_q <= 1'b1;
			end
			if (finish) begin
				res.valid <= 1'b1;
			end else if (res.ready) begin
				res.valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head_vld) begin
						if (head.first) begin
							count_q <= '0;
						end
						rd_addr_q <= '0;
						supp_q    <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!(vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						res.keep      <= !supp_q;
						res.kept_slot <= (!supp_q && room) ? slot_ext[gbn_pkg::SLOT_W-1:0] : '0;
						res.list_full <= !supp_q && !room;
						if (!supp_q && room) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gbn_pkg::CNT_W'(gbn_pkg::MAX_KEPT))
		else $error("kept count above list size");
	a_full_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.list_full |-> res.keep && (res.kept_slot == '0))
		else $error("list_full on a box not kept");
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !(vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5))
		else $error("result taken with compares in flight");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> rd_addr_q < count_q)
		else $error("read beyond kept entries");
	a_grow_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !finish |=> $stable(count_q))
		else $error("count moved while result stalled");
`endif

endmodule
`default_nettype wire

// ----- sv/greedy_box_nms.sv -----
// channel   dir  handshake            payload
// box       in   valid/ready          box_x, box_y, box_w, box_h, first_of_set
// res       out  valid/ready          keep, kept_slot, list_full
// cfg       in   cfg_we (no wait)     cfg_wdata = iou_threshold
//
// Each request passes a start state, a scan that reads one kept box per cycle
// until the kept list is done, a drain of the compare pipe, and a done state
// that posts the result once the result channel can take it.
// A two-entry input queue takes requests while the back end works; a waiting
// result holds the back end, and a full queue then holds the input.
// Reset empties the queue and the kept count and sets the threshold to 115.
`default_nettype none
module greedy_box_nms (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	gbn_box_if.sink                         box,
	gbn_res_if.source                       res,
	input  wire logic                       cfg_we,
	input  wire logic [gbn_pkg::THR_W-1:0]  cfg_wdata
);

	logic [gbn_pkg::THR_W-1:0] thr_q;
	gbn_pkg::qent_t            head;
	logic                      head_vld;
	logic                      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= gbn_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	gbn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.box      (box),
		.pop      (pop),
		.head     (head),
		.head_vld (head_vld)
	);

	gbn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_vld (head_vld),
		.pop      (pop),
		.thr      (thr_q),
		.res      (res)
	);

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic signed [gbn_pkg::COORD_BITS-1:0] x;
		logic signed [gbn_pkg::COORD_BITS-1:0] y;
		logic [gbn_pkg::COORD_BITS-1:0]        w;
		logic [gbn_pkg::COORD_BITS-1:0]        h;
		logic                                  first;
	} box_req_t;

	typedef struct {
		logic                       keep;
		logic [gbn_pkg::SLOT_W-1:0] slot;
		logic                       full;
	} verdict_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [gbn_pkg::THR_W-1:0] cfg_wdata = '0;

	gbn_box_if box_ch();
	gbn_res_if res_ch();

	greedy_box_nms dut (
		.clk(clk),
		.arst_n(arst_n),
		.box(box_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// kept list as the block should hold it
	box_req_t kept_list[gbn_pkg::MAX_KEPT];
	int       kept_n = 0;
	int       thr_now = int'(gbn_pkg::THR_RESET);

	box_req_t box_reqs_pending[$];
	verdict_t verdicts_due[$];
	box_req_t on_bus;

	int boxes_queued = 0;
	int results_seen = 0;
	int fails = 0;
	int n_kept = 0, n_suppressed = 0, n_full = 0, n_thr_writes = 0;
	int src_gap = 0, snk_gap = 0;
	bit src_steady = 1'b0, snk_steady = 1'b0;

	function automatic verdict_t judge_box(box_req_t b);
		verdict_t v;
		longint bx, by, bw, bh, kx, ky, kw, kh;
		longint lft, rgt, top, bot, ovl, uni;
		v.keep = 1'b1;
		v.slot = '0;
		v.full = 1'b0;
		bx = b.x;
		by = b.y;
		bw = b.w;
		bh = b.h;
		if (b.first)
			kept_n = 0;
		for (int i = 0; i < kept_n; i++) begin
			kx = kept_list[i].x;
			ky = kept_list[i].y;
			kw = kept_list[i].w;
			kh = kept_list[i].h;
			lft = (bx > kx) ? bx : kx;
			rgt = (bx + bw < kx + kw) ? bx + bw : kx + kw;
			top = (by > ky) ? by : ky;
			bot = (by + bh < ky + kh) ? by + bh : ky + kh;
			ovl = (rgt <= lft || bot <= top) ? 0 : (rgt - lft) * (bot - top);
			uni = bw * bh + kw * kh - ovl;
			// zero union never suppresses
			if (uni != 0 && ovl * 256 > longint'(thr_now) * uni) begin
				v.keep = 1'b0;
				break;
			end
		end
		if (!v.keep) begin
			n_suppressed++;
		end else if (kept_n < gbn_pkg::MAX_KEPT) begin
			kept_list[kept_n] = b;
			v.slot = gbn_pkg::SLOT_W'(kept_n);
			kept_n++;
			n_kept++;
		end else begin
			v.full = 1'b1;
			n_full++;
		end
		return v;
	endfunction

	function automatic int pick_gap(bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_ch.valid <= 1'b0;
			src_gap = 0;
		end else begin
			if (box_ch.valid && box_ch.ready)
				verdicts_due.insert(verdicts_due.size(), judge_box(on_bus));
			if (!box_ch.valid || box_ch.ready) begin
				if ($urandom_range(0, 149) == 0)
					src_steady = !src_steady;
				if (src_gap > 0) begin
					src_gap--;
					box_ch.valid <= 1'b0;
				end else if (box_reqs_pending.size() > 0) begin
					on_bus = box_reqs_pending.pop_front();
					box_ch.box_x <= on_bus.x;
					box_ch.box_y <= on_bus.y;
					box_ch.box_w <= on_bus.w;
					box_ch.box_h <= on_bus.h;
					box_ch.first_of_set <= on_bus.first;
					box_ch.valid <= 1'b1;
					src_gap = pick_gap(src_steady);
				end else begin
					box_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (verdicts_due.size() == 0) begin
					fails++;
					$display("%0t: unexpected result keep=%0b slot=%0d full=%0b", $time,
						res_ch.keep, res_ch.kept_slot, res_ch.list_full);
				end else begin
					want = verdicts_due.pop_front();
					if (res_ch.keep !== want.keep || res_ch.kept_slot !== want.slot ||
						res_ch.list_full !== want.full) begin
						fails++;
						$display("%0t: keep/slot/full expected %0b/%0d/%0b, got %0b/%0d/%0b",
							$time, want.keep, want.slot, want.full,
							res_ch.keep, res_ch.kept_slot, res_ch.list_full);
					end
				end
			end
			if ($urandom_range(0, 149) == 0)
				snk_steady = !snk_steady;
			if (snk_gap > 0) begin
				snk_gap--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if ((res_ch.valid && res_ch.ready) || $urandom_range(0, 9) == 0)
					snk_gap = pick_gap(snk_steady);
			end
		end
	end

	task automatic add_req(box_req_t b);
		box_reqs_pending.insert(box_reqs_pending.size(), b);
		boxes_queued++;
	endtask

	task automatic add_box(int x, int y, int w, int h, bit first);
		box_req_t b;
		b.x = gbn_pkg::COORD_BITS'(x);
		b.y = gbn_pkg::COORD_BITS'(y);
		b.w = gbn_pkg::COORD_BITS'(w);
		b.h = gbn_pkg::COORD_BITS'(h);
		b.first = first;
		add_req(b);
	endtask

	// one set: clustered boxes around a few anchors, plus empty boxes, noise and repeats;
	// grid sets hold many disjoint boxes to overrun the list
	task automatic gen_set(int len, bit grid);
		int ax[4], ay[4], aw[4], ah[4];
		int k, r, s, x, y, w, h;
		bit first;
		box_req_t so_far[$];
		box_req_t b;
		for (int a = 0; a < 4; a++) begin
			ax[a] = int'($urandom_range(0, 3000)) - 1500;
			ay[a] = int'($urandom_range(0, 3000)) - 1500;
			aw[a] = $urandom_range(4, 600);
			ah[a] = $urandom_range(4, 600);
		end
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			first = (i == 0) || ($urandom_range(0, 49) == 0);
			if (grid && r >= 10) begin
				x = -2048 + (i % 32) * 128 + int'($urandom_range(0, 20));
				y = -2048 + (i / 32) * 128 + int'($urandom_range(0, 20));
				w = $urandom_range(1, 100);
				h = $urandom_range(1, 100);
				first = (i == 0);
			end else if (!grid && r < 60) begin
				k = $urandom_range(0, 3);
				s = aw[k] / 4;
				x = ax[k] + int'($urandom_range(0, 2 * s)) - s;
				w = aw[k] + int'($urandom_range(0, 2 * s)) - s;
				s = ah[k] / 4;
				y = ay[k] + int'($urandom_range(0, 2 * s)) - s;
				h = ah[k] + int'($urandom_range(0, 2 * s)) - s;
			end else if (!grid && r < 85 && r >= 75) begin
				k = $urandom_range(0, 3);
				x = ax[k] + int'($urandom_range(0, 40)) - 20;
				y = ay[k] + int'($urandom_range(0, 40)) - 20;
				w = $urandom_range(0, 300);
				h = $urandom_range(0, 300);
				if ($urandom_range(0, 1))
					w = 0;
				else
					h = 0;
			end else if (!grid && r >= 85 && so_far.size() > 0 && i > 0) begin
				b = so_far[$urandom_range(0, so_far.size() - 1)];
				b.first = first;
				add_req(b);
				so_far.insert(so_far.size(), b);
				continue;
			end else begin
				x = $urandom;
				y = $urandom;
				w = $urandom;
				h = $urandom;
			end
			b.x = gbn_pkg::COORD_BITS'(x);
			b.y = gbn_pkg::COORD_BITS'(y);
			b.w = gbn_pkg::COORD_BITS'(w);
			b.h = gbn_pkg::COORD_BITS'(h);
			b.first = first;
			add_req(b);
			so_far.insert(so_far.size(), b);
		end
	endtask

	task automatic wait_idle();
		while (results_seen < boxes_queued)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_threshold(int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= gbn_pkg::THR_W'(v);
		thr_now = v;
		n_thr_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int thr_plan[8];
		int start_n;
		thr_plan = '{115, 0, 256, 511, 1, 255, 0, 0};
		box_ch.valid = 1'b0;
		box_ch.box_x = '0;
		box_ch.box_y = '0;
		box_ch.box_w = '0;
		box_ch.box_h = '0;
		box_ch.first_of_set = 1'b0;
		res_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				wait_idle();
				set_threshold(p >= 6 ? int'($urandom_range(20, 230)) : thr_plan[p]);
			end
			start_n = boxes_queued;
			case (p)
			0: begin
				// reset threshold: extremes, duplicates, touching edges, empty boxes
				add_box(-2048, -2048, 4095, 4095, 1);
				add_box(-2048, -2048, 4095, 4095, 0);
				add_box(2047, 2047, 4095, 4095, 0);
				add_box(0, 0, 0, 10, 0);
				add_box(0, 0, 0, 10, 0);
				add_box(0, 0, 0, 0, 1);
				add_box(0, 0, 100, 100, 0);
				add_box(10, 0, 100, 100, 0);
				add_box(60, 0, 100, 100, 0);
				add_box(-1, 0, 2048, 1, 1);
				gen_set(70, 1'b1);
			end
			1: begin
				// zero threshold: any overlap suppresses, touching does not
				add_box(0, 0, 10, 10, 1);
				add_box(9, 9, 10, 10, 0);
				add_box(10, 0, 10, 10, 0);
			end
			2, 3: begin
				// identical box survives at or above full threshold
				add_box(100, 100, 50, 50, 1);
				add_box(100, 100, 50, 50, 0);
			end
			default: ;
			endcase
			while (boxes_queued - start_n < 160) begin
				if ($urandom_range(0, 99) < 6)
					gen_set($urandom_range(66, 80), 1'b1);
				else if ($urandom_range(0, 99) < 75)
					gen_set($urandom_range(1, 20), 1'b0);
				else
					gen_set($urandom_range(20, 50), 1'b0);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (verdicts_due.size() != 0) begin
			fails++;
			$display("%0t: %0d results never arrived", $time, verdicts_due.size());
		end
		$display("%0d boxes checked: %0d kept and stored, %0d suppressed, %0d kept with list full",
			results_seen, n_kept, n_suppressed, n_full);
		$display("%0d threshold settings written, including 0, 256 and 511", n_thr_writes);
		if (fails == 0)
			$display("greedy_box_nms: match");
		else
			$display("greedy_box_nms: mismatch");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("timeout at %0t", $time);
		$display("greedy_box_nms: mismatch");
		$finish;
	end

endmodule
